// ----- src/swr_power_meter_assert.svh -----
// assertion macros for the swr power meter
`ifndef SWR_POWER_METER_ASSERT_SVH
`define SWR_POWER_METER_ASSERT_SVH

`define SWR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("swr_power_meter: implication failed");

`define SWR_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("swr_power_meter: forbidden condition");

`endif

// ----- src/swr_pkg.sv -----
// shared types and constants of the swr power meter
package swr_pkg;

  localparam int unsigned MV_W   = 14;
  localparam int unsigned CODE_W = 7;
  localparam int unsigned CAL_W  = 37;
  localparam int unsigned PWR_W  = 12;
  localparam int unsigned SWR_W  = 10;

  localparam logic [CODE_W-1:0] QUAD_RESET = 7'd14;
  localparam logic [CODE_W-1:0] LIN_RESET  = 7'd4;
  localparam logic [CODE_W-1:0] MIN_RESET  = 7'd10;

  localparam logic [PWR_W-1:0] POWER_MAX = 12'd4095;
  localparam logic [SWR_W-1:0] SWR_OVER  = 10'd999;

  localparam logic [CAL_W:0] ROUND_HALF = 38'd5000000;
  localparam logic [CAL_W:0] SAT_LIMIT  = 38'd40960000000;
  localparam logic [29:0]    RECIP      = 30'd900719925;
  localparam logic [16:0]    DIV_LO     = 17'd78125;

  typedef enum logic [1:0] {
    CFG_QUAD_GAIN = 2'd0,
    CFG_LIN_GAIN  = 2'd1,
    CFG_MIN_POWER = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic             sat;
    logic [PWR_W-1:0] q;
  } pwr_t;

endpackage

// ----- src/swr_cal.sv -----
// calibration pipeline: a*v^2 + b*v for both detectors, scaled by 1e8
module swr_cal (
  input  logic                              clk_i,
  input  logic [swr_pkg::CODE_W-1:0]        quad_i,
  input  logic [swr_pkg::CODE_W-1:0]        lin_i,
  input  logic [swr_pkg::MV_W-1:0]          fwd_i,
  input  logic [swr_pkg::MV_W-1:0]          rev_i,
  output logic [swr_pkg::CAL_W-1:0]         pf_o,
  output logic [swr_pkg::CAL_W-1:0]         pr_o
);

  logic [27:0] sq_f_q, sq_r_q;
  logic [20:0] lm_f_q, lm_r_q;
  logic [35:0] a_f_q, a_r_q;
  logic [34:0] b_f_q, b_r_q;
  logic [swr_pkg::CAL_W-1:0] pf_q, pr_q;
  logic [7:0] gain;

  assign gain = 8'd100 + {1'b0, quad_i};

  always_ff @(posedge clk_i) begin
    sq_f_q <= 28'(fwd_i) * 28'(fwd_i);
    sq_r_q <= 28'(rev_i) * 28'(rev_i);
    lm_f_q <= 21'(lin_i) * 21'(fwd_i);
    lm_r_q <= 21'(lin_i) * 21'(rev_i);
    a_f_q  <= 36'(gain) * 36'(sq_f_q);
    a_r_q  <= 36'(gain) * 36'(sq_r_q);
    b_f_q  <= 35'(lm_f_q) * 35'd10000;
    b_r_q  <= 35'(lm_r_q) * 35'd10000;
    pf_q   <= 37'(a_f_q) + 37'(b_f_q);
    pr_q   <= 37'(a_r_q) + 37'(b_r_q);
  end

  assign pf_o = pf_q;
  assign pr_o = pr_q;

endmodule

// ----- src/swr_pwr.sv -----
// power in tenths of a watt: rounded divide by 1e7 via reciprocal
module swr_pwr (
  input  logic                      clk_i,
  input  logic [swr_pkg::CAL_W-1:0] pf_i,
  output swr_pkg::pwr_t             pwr_o
);

  logic [swr_pkg::CAL_W:0] x;
  logic [28:0] y_a_q, y_b_q, y_c_q;
  logic        sat_a_q, sat_b_q, sat_c_q;
  logic [58:0] prod_b_q;
  logic [11:0] q0;
  logic [11:0] q0_c_q;
  logic [28:0] t_c_q;
  logic [28:0] r;
  swr_pkg::pwr_t pwr_q;

  assign x  = {1'b0, pf_i} + swr_pkg::ROUND_HALF;
  assign q0 = prod_b_q[57:46];
  assign r  = y_c_q - t_c_q;

  always_ff @(posedge clk_i) begin
    sat_a_q  <= x >= swr_pkg::SAT_LIMIT;
    y_a_q    <= x[35:7];
    prod_b_q <= 59'(y_a_q) * 59'(swr_pkg::RECIP);
    y_b_q    <= y_a_q;
    sat_b_q  <= sat_a_q;
    q0_c_q   <= q0;
    t_c_q    <= 29'(q0) * 29'(swr_pkg::DIV_LO);
    y_c_q    <= y_b_q;
    sat_c_q  <= sat_b_q;
    pwr_q.sat <= sat_c_q;
    pwr_q.q   <= (r >= 29'(swr_pkg::DIV_LO)) ? q0_c_q + 12'd1 : q0_c_q;
  end

  assign pwr_o = pwr_q;

endmodule

// ----- src/swr_gamma.sv -----
// reflection coefficient: fraction divide then integer square root
module swr_gamma #(
  parameter int unsigned F = 16
) (
  input  logic                      clk_i,
  input  logic [swr_pkg::CAL_W-1:0] pf_i,
  input  logic [swr_pkg::CAL_W-1:0] pr_i,
  output logic [F-1:0]              g_o,
  output logic                      ovr_o
);

  localparam int unsigned W  = swr_pkg::CAL_W;
  localparam int unsigned QW = 2 * F;

  logic [W-1:0]  fr_q [QW];
  logic [W-1:0]  fd_q [QW];
  logic [QW-1:0] fq_q [QW];
  logic          fo_q [QW];

  logic [QW-1:0] sx_q [F];
  logic [QW-1:0] sr_q [F];
  logic          so_q [F];

  for (genvar i = 0; i < QW; i++) begin : g_frac
    logic [W-1:0]  r_in, den_in;
    logic [QW-1:0] q_in;
    logic          o_in;
    logic [W:0]    r2;
    logic          ge;
    if (i == 0) begin : g_first
      assign o_in   = pr_i >= pf_i;
      assign r_in   = o_in ? '0 : pr_i;
      assign den_in = pf_i;
      assign q_in   = '0;
    end else begin : g_next
      assign o_in   = fo_q[i-1];
      assign r_in   = fr_q[i-1];
      assign den_in = fd_q[i-1];
      assign q_in   = fq_q[i-1];
    end
    assign r2 = {r_in, 1'b0};
    assign ge = r2 >= {1'b0, den_in};
    always_ff @(posedge clk_i) begin
      fr_q[i] <= ge ? W'(r2 - {1'b0, den_in}) : r2[W-1:0];
      fd_q[i] <= den_in;
      fq_q[i] <= {q_in[QW-2:0], ge};
      fo_q[i] <= o_in;
    end
  end

  for (genvar j = 0; j < F; j++) begin : g_sqrt
    localparam logic [QW-1:0] BIT = QW'(1) << (2 * (F - 1 - j));
    logic [QW-1:0] x_in, res_in;
    logic          o_in;
    logic [QW:0]   sum;
    logic          ge;
    if (j == 0) begin : g_first
      assign x_in   = fq_q[QW-1];
      assign res_in = '0;
      assign o_in   = fo_q[QW-1];
    end else begin : g_next
      assign x_in   = sx_q[j-1];
      assign res_in = sr_q[j-1];
      assign o_in   = so_q[j-1];
    end
    assign sum = {1'b0, res_in} + {1'b0, BIT};
    assign ge  = {1'b0, x_in} >= sum;
    always_ff @(posedge clk_i) begin
      sx_q[j] <= ge ? QW'({1'b0, x_in} - sum) : x_in;
      sr_q[j] <= ge ? (res_in >> 1) + BIT : res_in >> 1;
      so_q[j] <= o_in;
    end
  end

  assign g_o   = sr_q[F-1][F-1:0];
  assign ovr_o = so_q[F-1];

endmodule

// ----- src/swr_ratio.sv -----
// swr from gamma: overflow test and restoring divide, one quotient bit a stage
module swr_ratio #(
  parameter int unsigned F = 16
) (
  input  logic                      clk_i,
  input  logic [F-1:0]              g_i,
  input  logic                      ovr_i,
  output logic [swr_pkg::SWR_W-1:0] swr_o
);

  localparam int unsigned QB  = swr_pkg::SWR_W;
  localparam int unsigned RW  = F + 9;
  localparam int unsigned DW  = F + 2;
  localparam int unsigned CW  = F + 11;
  localparam int unsigned NW  = F + 15;
  localparam logic [F:0]  ONE = (F + 1)'(1) << F;

  logic [F:0]    n, d;
  logic          big;
  logic [RW-1:0] rem_q [QB+1];
  logic [DW-1:0] dd_q  [QB+1];
  logic [QB-1:0] quo_q [QB+1];
  logic          ovr_q [QB+1];

  assign n   = ONE + {1'b0, g_i};
  assign d   = ONE - {1'b0, g_i};
  assign big = (NW'(n) * NW'(1000)) > (NW'(d) * NW'(9985));

  always_ff @(posedge clk_i) begin
    rem_q[0] <= RW'(RW'(n) * RW'(200)) + RW'(d);
    dd_q[0]  <= {d, 1'b0};
    quo_q[0] <= '0;
    ovr_q[0] <= ovr_i | big;
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    logic [CW-1:0] cmp;
    logic          ge;
    assign cmp = CW'(dd_q[k]) << (QB - 1 - k);
    assign ge  = CW'(rem_q[k]) >= cmp;
    always_ff @(posedge clk_i) begin
      rem_q[k+1] <= ge ? RW'(CW'(rem_q[k]) - cmp) : rem_q[k];
      dd_q[k+1]  <= dd_q[k];
      quo_q[k+1] <= quo_q[k] | (QB'(ge) << (QB - 1 - k));
      ovr_q[k+1] <= ovr_q[k];
    end
  end

  assign swr_o = ovr_q[QB] ? swr_pkg::SWR_OVER : quo_q[QB];

endmodule

// ----- src/swr_power_meter.sv -----
// top level: forward power and swr from forward and reverse detector voltages
// done_o follows each accepted beat through the vld_q valid shift register
// throughput: one beat per cycle, busy is never raised
// done_o marks each result for one cycle; results cannot be held off
// reset: async active low, clears the valid line and loads register defaults
`include "swr_power_meter_assert.svh"

module swr_power_meter #(
  parameter int unsigned GAMMA_FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [swr_pkg::MV_W-1:0]    fwd_mv_i,
  input  logic [swr_pkg::MV_W-1:0]    rev_mv_i,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [swr_pkg::CODE_W-1:0]  cfg_data_i,
  output logic                        done_o,
  output logic [swr_pkg::PWR_W-1:0]   power_tenths_o,
  output logic [swr_pkg::SWR_W-1:0]   swr_hundredths_o
);

  localparam int unsigned F   = GAMMA_FRAC_BITS;
  localparam int unsigned LAT = 3 * F + 15;
  localparam int unsigned PD  = 3 * F + 7;

  logic [swr_pkg::CODE_W-1:0] quad_q, lin_q, min_q;
  logic [LAT-1:0] vld_q, vld_d;
  logic accept;

  logic [swr_pkg::CAL_W-1:0] pf, pr;
  swr_pkg::pwr_t pwr;
  swr_pkg::pwr_t pd_q [PD];
  logic [F-1:0] g;
  logic g_ovr;
  logic [swr_pkg::SWR_W-1:0] swr_raw;
  logic low;

  logic [swr_pkg::PWR_W-1:0] pwr_out_q;
  logic [swr_pkg::SWR_W-1:0] swr_out_q;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quad_q <= swr_pkg::QUAD_RESET;
      lin_q  <= swr_pkg::LIN_RESET;
      min_q  <= swr_pkg::MIN_RESET;
    end else if (cfg_we_i) begin
      case (swr_pkg::cfg_idx_e'(cfg_idx_i))
        swr_pkg::CFG_QUAD_GAIN: quad_q <= cfg_data_i;
        swr_pkg::CFG_LIN_GAIN:  lin_q  <= cfg_data_i;
        swr_pkg::CFG_MIN_POWER: min_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign vld_d = {vld_q[LAT-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  swr_cal u_cal (
    .clk_i  (clk_i),
    .quad_i (quad_q),
    .lin_i  (lin_q),
    .fwd_i  (fwd_mv_i),
    .rev_i  (rev_mv_i),
    .pf_o   (pf),
    .pr_o   (pr)
  );

  swr_pwr u_pwr (
    .clk_i (clk_i),
    .pf_i  (pf),
    .pwr_o (pwr)
  );

  swr_gamma #(.F(F)) u_gamma (
    .clk_i (clk_i),
    .pf_i  (pf),
    .pr_i  (pr),
    .g_o   (g),
    .ovr_o (g_ovr)
  );

  swr_ratio #(.F(F)) u_ratio (
    .clk_i (clk_i),
    .g_i   (g),
    .ovr_i (g_ovr),
    .swr_o (swr_raw)
  );

  // align power with the swr path
  always_ff @(posedge clk_i) begin
    pd_q[0] <= pwr;
    for (int unsigned i = 1; i < PD; i++) begin
      pd_q[i] <= pd_q[i-1];
    end
  end

  assign low = ~pd_q[PD-1].sat & (pd_q[PD-1].q < swr_pkg::PWR_W'(min_q));

  always_ff @(posedge clk_i) begin
    if (vld_q[LAT-2]) begin
      pwr_out_q <= pd_q[PD-1].sat ? swr_pkg::POWER_MAX : pd_q[PD-1].q;
      swr_out_q <= low ? '0 : swr_raw;
    end
  end

  assign done_o           = vld_q[LAT-1];
  assign power_tenths_o   = pwr_out_q;
  assign swr_hundredths_o = swr_out_q;

  `SWR_ASSERT_IMP(a_done_latency, done_o, $past(accept, LAT))
  `SWR_ASSERT_IMP(a_swr_range, done_o, swr_hundredths_o <= swr_pkg::SWR_OVER)
  `SWR_ASSERT_IMP(a_low_power, done_o && swr_hundredths_o != '0,
                  power_tenths_o >= swr_pkg::PWR_W'(min_q))

endmodule
